// ===== rtl/sitda_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, pipeline payload types and the BCD helper functions.
// Depends on nothing; every other file of the block imports it.
package sitda_pkg;

	localparam int VALUE_W      = 32;
	localparam int NUM_DIGITS   = 10;
	localparam int DIGIT_W      = 4;
	localparam int BCD_W        = NUM_DIGITS * DIGIT_W;
	localparam int IDX_W        = 4;
	localparam int DABBLE_STEPS = 8;
	localparam int CHAR_W       = 8;

	localparam logic [CHAR_W-1:0]  DIGIT_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0]  DIGIT_NINE = 8'h39;
	localparam logic [CHAR_W-1:0]  MINUS_SIGN = 8'h2D;
	localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

	// Working word of the shift-and-add-3 conversion.
	typedef struct packed {
		logic               neg;
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} dd_t;

	// Finished conversion as handed to the serialiser.
	typedef struct packed {
		logic             neg;
		logic [BCD_W-1:0] bcd;
		logic [IDX_W-1:0] top_idx;
	} conv_t;

	// Runs DABBLE_STEPS steps of the shift-and-add-3 conversion.
	function automatic dd_t dabble_steps(input dd_t d);
		dd_t                        r;
		logic [BCD_W+VALUE_W-1:0]   sh;
		sh = {d.bcd, d.bin};
		for (int s = 0; s < DABBLE_STEPS; s++) begin
			for (int k = 0; k < NUM_DIGITS; k++) begin
				if (sh[VALUE_W+k*DIGIT_W +: DIGIT_W] >= DABBLE_MIN) begin
					sh[VALUE_W+k*DIGIT_W +: DIGIT_W] =
						sh[VALUE_W+k*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
				end
			end
			sh = sh << 1;
		end
		r.neg = d.neg;
		r.bcd = sh[BCD_W+VALUE_W-1:VALUE_W];
		r.bin = sh[VALUE_W-1:0];
		return r;
	endfunction

	// Index of the most significant non-zero digit; zero for a value of zero.
	function automatic logic [IDX_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int k = 1; k < NUM_DIGITS; k++) begin
			if (bcd[k*DIGIT_W +: DIGIT_W] != '0) begin
				idx = IDX_W'(k);
			end
		end
		return idx;
	endfunction

endpackage

// ===== rtl/sitda_convert.sv =====
// Six-stage conversion pipeline: sign and magnitude, four shift-and-add-3 stages,
// and a leading-digit search. Depends on sitda_pkg.
// A stage moves on when the stage after it is empty or moving on itself.
module sitda_convert import sitda_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [VALUE_W-1:0] in_value,
	output logic               in_ready,
	output logic               conv_valid,
	output conv_t              conv_data,
	input  logic               conv_ready
);

	logic  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	dd_t   dd_s1, dd_s2, dd_s3, dd_s4, dd_s5;
	conv_t conv_s6;
	logic  rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	logic  neg;
	dd_t   dd_in;

	assign rdy6 = !valid_s6 || conv_ready;
	assign rdy5 = !valid_s5 || rdy6;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign in_ready   = rdy1;
	assign conv_valid = valid_s6;
	assign conv_data  = conv_s6;

	// The magnitude of the most negative value wraps to 2^31, which is still correct unsigned.
	always_comb begin
		neg       = in_value[VALUE_W-1];
		dd_in.neg = neg;
		dd_in.bcd = '0;
		dd_in.bin = neg ? (VALUE_W'(0) - in_value) : in_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) dd_s1 <= dd_in;
		if (rdy2) dd_s2 <= dabble_steps(dd_s1);
		if (rdy3) dd_s3 <= dabble_steps(dd_s2);
		if (rdy4) dd_s4 <= dabble_steps(dd_s3);
		if (rdy5) dd_s5 <= dabble_steps(dd_s4);
		if (rdy6) begin
			conv_s6.neg     <= dd_s5.neg;
			conv_s6.bcd     <= dd_s5.bcd;
			conv_s6.top_idx <= top_digit(dd_s5.bcd);
		end
	end

endmodule

// ===== rtl/sitda_serialiser.sv =====
// Serialiser: turns one converted item into a run of ASCII characters,
// sign first, then digits from the most significant. Depends on sitda_pkg.
// The result sits in an output register so the next item can load meanwhile.
module sitda_serialiser import sitda_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              conv_valid,
	input  conv_t             conv_data,
	output logic              conv_ready,
	output logic              char_valid,
	output logic [CHAR_W-1:0] char_code,
	output logic              last_char,
	input  logic              char_stall
);

	logic              busy_q;
	logic              sign_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [IDX_W-1:0]  pos_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_code_q;
	logic              out_last_q;

	logic              out_free;
	logic              emit;
	logic              emit_last;
	logic              load;
	logic [CHAR_W-1:0] next_code;

	assign out_free   = !out_valid_q || !char_stall;
	assign emit       = busy_q && out_free;
	assign emit_last  = !sign_q && (pos_q == '0);
	assign conv_ready = !busy_q || (emit && emit_last);
	assign load       = conv_valid && conv_ready;

	always_comb begin
		if (sign_q) begin
			next_code = MINUS_SIGN;
		end else begin
			next_code = DIGIT_ZERO + CHAR_W'(bcd_q[pos_q*DIGIT_W +: DIGIT_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && emit_last) begin
				busy_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sign_q <= conv_data.neg;
			bcd_q  <= conv_data.bcd;
			pos_q  <= conv_data.top_idx;
		end else if (emit) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (pos_q != '0) begin
				pos_q <= pos_q - 1'b1;
			end
		end
		if (emit) begin
			out_code_q <= next_code;
			out_last_q <= emit_last;
		end
	end

	assign char_valid = out_valid_q;
	assign char_code  = out_code_q;
	assign last_char  = out_last_q;

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text converter, top level.
// Input channel: value with valid/stall; an item is taken when valid is high and stall low.
// Output channel: char_code and last_char with char_valid/char_stall, one character per item
// of output, most significant first, '-' ahead of a negative value, no leading zeros,
// and last_char set on the final character of each value's text.
// The first character of a value reaches the output register after the six pipeline
// stages and a load into the serialiser.
// Throughput: an input item's text has 1 to 11 characters; the serialiser emits one
// character per cycle while char_stall does not hold it, and so sets the rate.
// The conversion pipeline holds up to six more values while the serialiser works.
// Reset clears every valid bit; nothing else carries over between items.
// While char_stall is high the output character holds, the serialiser waits, and the
// pipeline fills up until stall is raised on the input side. Nothing is lost or repeated.
// Depends on sitda_pkg, sitda_convert and sitda_serialiser.
module signed_int_to_decimal_ascii import sitda_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      stall,
	output logic                      char_valid,
	output logic [CHAR_W-1:0]         char_code,
	output logic                      last_char,
	input  logic                      char_stall
);

	logic  in_ready;
	logic  conv_valid;
	conv_t conv_data;
	logic  conv_ready;

	assign stall = !in_ready;

	sitda_convert u_convert (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid),
		.in_value   ($unsigned(value)),
		.in_ready   (in_ready),
		.conv_valid (conv_valid),
		.conv_data  (conv_data),
		.conv_ready (conv_ready)
	);

	sitda_serialiser u_serialiser (
		.clk        (clk),
		.arst_n     (arst_n),
		.conv_valid (conv_valid),
		.conv_data  (conv_data),
		.conv_ready (conv_ready),
		.char_valid (char_valid),
		.char_code  (char_code),
		.last_char  (last_char),
		.char_stall (char_stall)
	);

	// A converted item waiting for the serialiser must not be dropped or altered.
	a_conv_hold: assert property (@(posedge clk) disable iff (!arst_n)
		conv_valid && !conv_ready |=> conv_valid && $stable(conv_data))
		else $error("converted item changed while waiting for the serialiser");

	// The sign is never the final character of a run.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && (char_code == MINUS_SIGN) |-> !last_char)
		else $error("minus sign flagged as last character");

	// Only a sign or a decimal digit is ever emitted.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (char_code == MINUS_SIGN) ||
			((char_code >= DIGIT_ZERO) && (char_code <= DIGIT_NINE)))
		else $error("character outside the decimal text set");

endmodule
